>>> src/cwhm_pkg.sv
package cwhm_pkg;

    // field widths
    localparam int COV_W   = 24;
    localparam int TALLY_W = 5;
    localparam int IDX_W   = 3;

    // window depth default
    localparam int WINDOW_LENGTH_DEF = 10;

    // register reset values
    localparam logic [COV_W-1:0]   LOST_LEVEL_RST      = 24'd655360;
    localparam logic [COV_W-1:0]   EMERGENCY_LEVEL_RST = 24'd65536;
    localparam logic [COV_W-1:0]   CRITICAL_LEVEL_RST  = 24'd32768;
    localparam logic [TALLY_W-1:0] EMERGENCY_MIN_RST   = 5'd3;
    localparam logic [TALLY_W-1:0] CRITICAL_MIN_RST    = 5'd5;

    typedef enum logic [IDX_W-1:0] {
        REG_LOST_LEVEL      = 3'd0,
        REG_EMERGENCY_LEVEL = 3'd1,
        REG_CRITICAL_LEVEL  = 3'd2,
        REG_EMERGENCY_MIN   = 3'd3,
        REG_CRITICAL_MIN    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLASS_NORMAL    = 2'd0,
        CLASS_CRITICAL  = 2'd1,
        CLASS_EMERGENCY = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        STATUS_ACTIVE    = 2'd0,
        STATUS_CRITICAL  = 2'd1,
        STATUS_EMERGENCY = 2'd2,
        STATUS_LOST      = 2'd3
    } status_t;

    typedef struct packed {
        logic [COV_W-1:0]   lost_level;
        logic [COV_W-1:0]   emergency_level;
        logic [COV_W-1:0]   critical_level;
        logic [TALLY_W-1:0] emergency_count_min;
        logic [TALLY_W-1:0] critical_count_min;
    } cfg_t;

    // classifier result handed to the window
    typedef struct packed {
        logic   lost;
        class_t cls;
    } sample_class_t;

endpackage

>>> src/windowed_covariance_health_monitor_top.sv
// path: a sample is taken into the input register, then moves on to the result register
// when the output is free (m_ready high or the result register empty)
// throughput: one sample per cycle while m_ready stays high; the window and tallies update
// in the same cycle the sample moves from the input register to the result register
// reset (aresetn low, synchronous): window cleared to normal, tallies zero,
// registers back to their defaults, both pipeline stages empty
module windowed_covariance_health_monitor_top #(
    parameter int WINDOW_LENGTH = cwhm_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cwhm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cwhm_pkg::COV_W-1:0]   cfg_data,
    // sample input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cwhm_pkg::COV_W-1:0]   s_cov_x,
    input  logic [cwhm_pkg::COV_W-1:0]   s_cov_y,
    input  logic [cwhm_pkg::COV_W-1:0]   s_cov_z,
    input  logic                         s_invalid,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [cwhm_pkg::TALLY_W-1:0] m_emergency_tally,
    output logic [cwhm_pkg::TALLY_W-1:0] m_critical_tally
);

    cwhm_pkg::cfg_t               cfg_reg;
    cwhm_pkg::cfg_t               cfg_next;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [cwhm_pkg::COV_W-1:0]   cov_x_reg;
    logic [cwhm_pkg::COV_W-1:0]   cov_y_reg;
    logic [cwhm_pkg::COV_W-1:0]   cov_z_reg;
    logic                         invalid_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [1:0]                   status_reg;
    logic [cwhm_pkg::TALLY_W-1:0] emergency_tally_reg;
    logic [cwhm_pkg::TALLY_W-1:0] critical_tally_reg;
    logic                         out_free;
    logic                         advance;
    logic                         in_xfer;
    cwhm_pkg::sample_class_t      smp;
    cwhm_pkg::status_t            status;
    logic [cwhm_pkg::TALLY_W-1:0] emergency_tally;
    logic [cwhm_pkg::TALLY_W-1:0] critical_tally;

    // config register writes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cwhm_pkg::cfg_index_t'(cfg_index))
                cwhm_pkg::REG_LOST_LEVEL:      cfg_next.lost_level = cfg_data;
                cwhm_pkg::REG_EMERGENCY_LEVEL: cfg_next.emergency_level = cfg_data;
                cwhm_pkg::REG_CRITICAL_LEVEL:  cfg_next.critical_level = cfg_data;
                cwhm_pkg::REG_EMERGENCY_MIN: begin
                    cfg_next.emergency_count_min = cfg_data[cwhm_pkg::TALLY_W-1:0];
                end
                cwhm_pkg::REG_CRITICAL_MIN: begin
                    cfg_next.critical_count_min = cfg_data[cwhm_pkg::TALLY_W-1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lost_level          <= cwhm_pkg::LOST_LEVEL_RST;
            cfg_reg.emergency_level     <= cwhm_pkg::EMERGENCY_LEVEL_RST;
            cfg_reg.critical_level      <= cwhm_pkg::CRITICAL_LEVEL_RST;
            cfg_reg.emergency_count_min <= cwhm_pkg::EMERGENCY_MIN_RST;
            cfg_reg.critical_count_min  <= cwhm_pkg::CRITICAL_MIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline handshake
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cov_x_reg   <= s_cov_x;
            cov_y_reg   <= s_cov_y;
            cov_z_reg   <= s_cov_z;
            invalid_reg <= s_invalid;
        end
    end

    cwhm_classify u_classify (
        .cov_x   (cov_x_reg),
        .cov_y   (cov_y_reg),
        .cov_z   (cov_z_reg),
        .invalid (invalid_reg),
        .cfg     (cfg_reg),
        .smp     (smp)
    );

    cwhm_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .smp             (smp),
        .cfg             (cfg_reg),
        .status          (status),
        .emergency_tally (emergency_tally),
        .critical_tally  (critical_tally)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg          <= status;
            emergency_tally_reg <= emergency_tally;
            critical_tally_reg  <= critical_tally;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_emergency_tally = emergency_tally_reg;
    assign m_critical_tally  = critical_tally_reg;

endmodule

>>> src/cwhm_classify.sv
module cwhm_classify (
    input  logic [cwhm_pkg::COV_W-1:0] cov_x,
    input  logic [cwhm_pkg::COV_W-1:0] cov_y,
    input  logic [cwhm_pkg::COV_W-1:0] cov_z,
    input  logic                       invalid,
    input  cwhm_pkg::cfg_t             cfg,
    output cwhm_pkg::sample_class_t    smp
);

    logic [cwhm_pkg::COV_W-1:0] max_xy;
    logic [cwhm_pkg::COV_W-1:0] max_xyz;

    // largest of the three covariances
    always_comb begin
        max_xy  = (cov_y > cov_x) ? cov_y : cov_x;
        max_xyz = (cov_z > max_xy) ? cov_z : max_xy;
    end

    // lost check and class, emergency tested first
    always_comb begin
        smp.lost = invalid || (max_xyz > cfg.lost_level);
        priority if (max_xyz >= cfg.emergency_level) begin
            smp.cls = cwhm_pkg::CLASS_EMERGENCY;
        end else if (max_xyz >= cfg.critical_level) begin
            smp.cls = cwhm_pkg::CLASS_CRITICAL;
        end else begin
            smp.cls = cwhm_pkg::CLASS_NORMAL;
        end
    end

endmodule

>>> src/cwhm_window.sv
module cwhm_window #(
    parameter int WINDOW_LENGTH = cwhm_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  cwhm_pkg::sample_class_t      smp,
    input  cwhm_pkg::cfg_t               cfg,
    output cwhm_pkg::status_t            status,
    output logic [cwhm_pkg::TALLY_W-1:0] emergency_tally,
    output logic [cwhm_pkg::TALLY_W-1:0] critical_tally
);

    cwhm_pkg::class_t             window_reg [WINDOW_LENGTH];
    logic [cwhm_pkg::TALLY_W-1:0] emergency_count_reg;
    logic [cwhm_pkg::TALLY_W-1:0] critical_count_reg;
    logic [cwhm_pkg::TALLY_W-1:0] emergency_count_next;
    logic [cwhm_pkg::TALLY_W-1:0] critical_count_next;
    logic                         shift;
    logic                         old_emer;
    logic                         old_crit;
    logic                         new_emer;
    logic                         new_crit;

    assign shift = step && !smp.lost;

    // tally update: oldest entry leaves, new class enters
    always_comb begin
        old_emer = (window_reg[0] == cwhm_pkg::CLASS_EMERGENCY);
        old_crit = (window_reg[0] == cwhm_pkg::CLASS_CRITICAL);
        new_emer = (smp.cls == cwhm_pkg::CLASS_EMERGENCY);
        new_crit = (smp.cls == cwhm_pkg::CLASS_CRITICAL);
        emergency_count_next = emergency_count_reg;
        critical_count_next  = critical_count_reg;
        if (shift) begin
            emergency_count_next = emergency_count_reg
                                 + cwhm_pkg::TALLY_W'(new_emer)
                                 - cwhm_pkg::TALLY_W'(old_emer);
            critical_count_next  = critical_count_reg
                                 + cwhm_pkg::TALLY_W'(new_crit)
                                 - cwhm_pkg::TALLY_W'(old_crit);
        end
    end

    // window shift and tally registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                window_reg[i] <= cwhm_pkg::CLASS_NORMAL;
            end
            emergency_count_reg <= '0;
            critical_count_reg  <= '0;
        end else begin
            if (shift) begin
                for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
                    window_reg[i] <= window_reg[i+1];
                end
                window_reg[WINDOW_LENGTH-1] <= smp.cls;
            end
            emergency_count_reg <= emergency_count_next;
            critical_count_reg  <= critical_count_next;
        end
    end

    // status from the updated tallies: lost wins over all, then emergency wins over critical
    always_comb begin
        priority if (smp.lost) begin
            status = cwhm_pkg::STATUS_LOST;
        end else if (emergency_count_next >= cfg.emergency_count_min) begin
            status = cwhm_pkg::STATUS_EMERGENCY;
        end else if (critical_count_next >= cfg.critical_count_min) begin
            status = cwhm_pkg::STATUS_CRITICAL;
        end else begin
            status = cwhm_pkg::STATUS_ACTIVE;
        end
    end

    assign emergency_tally = emergency_count_next;
    assign critical_tally  = critical_count_next;

endmodule
